// File: hw/rtl/triangle_box_overlap_2d_top_assert.svh
// Assertion macros shared by the triangle and box overlap design files.
`ifndef TRIANGLE_BOX_OVERLAP_2D_TOP_ASSERT_SVH
`define TRIANGLE_BOX_OVERLAP_2D_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TBO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tbo_pkg.sv
// Package with the result codes and edge tables of the triangle and box overlap block.
package tbo_pkg;

  localparam int unsigned NUM_EDGES = 3;
  localparam int unsigned NUM_VERTS = 3;
  localparam int unsigned NUM_BOX   = 4;

  // Box corner order: min x, min y, max x, max y.
  localparam int unsigned BOX_MIN_X = 0;
  localparam int unsigned BOX_MIN_Y = 1;
  localparam int unsigned BOX_MAX_X = 2;
  localparam int unsigned BOX_MAX_Y = 3;

  // Second vertex of each edge; the first vertex has the edge's own index.
  localparam int unsigned EDGE_B [NUM_EDGES] = '{1, 2, 0};

  typedef enum logic [1:0] {
    REASON_OVERLAP = 2'd0,
    REASON_AXIS    = 2'd1,
    REASON_EDGE    = 2'd2
  } reason_t;

endpackage

// File: hw/rtl/tbo_if.sv
// Valid and ready stream interfaces for the input and result channels.
interface tbo_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] box_min_x;
  logic signed [COORD_BITS-1:0] box_min_y;
  logic signed [COORD_BITS-1:0] box_max_x;
  logic signed [COORD_BITS-1:0] box_max_y;
  logic signed [COORD_BITS-1:0] vertex0_x;
  logic signed [COORD_BITS-1:0] vertex0_y;
  logic signed [COORD_BITS-1:0] vertex1_x;
  logic signed [COORD_BITS-1:0] vertex1_y;
  logic signed [COORD_BITS-1:0] vertex2_x;
  logic signed [COORD_BITS-1:0] vertex2_y;

  modport source (
    output valid, box_min_x, box_min_y, box_max_x, box_max_y,
           vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_max_x, box_max_y,
           vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y,
    output ready
  );
endinterface

interface tbo_out_if;
  logic       valid;
  logic       ready;
  logic       overlaps;
  logic [1:0] reject_reason;

  modport source (
    output valid, overlaps, reject_reason,
    input  ready
  );
  modport sink (
    input  valid, overlaps, reject_reason,
    output ready
  );
endinterface

// File: hw/rtl/tbo_setup.sv
// First stage: edge normals and the bounding box test on x and y.
module tbo_setup #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] box [tbo_pkg::NUM_BOX],
  input  logic signed [COORD_BITS-1:0] vx [tbo_pkg::NUM_VERTS],
  input  logic signed [COORD_BITS-1:0] vy [tbo_pkg::NUM_VERTS],
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] box_out [tbo_pkg::NUM_BOX],
  output logic signed [COORD_BITS-1:0] vx_out [tbo_pkg::NUM_VERTS],
  output logic signed [COORD_BITS-1:0] vy_out [tbo_pkg::NUM_VERTS],
  output logic signed [COORD_BITS:0]   nx_out [tbo_pkg::NUM_EDGES],
  output logic signed [COORD_BITS:0]   ny_out [tbo_pkg::NUM_EDGES],
  output logic                         axis_sep_out
);
  import tbo_pkg::*;

  localparam int NW = COORD_BITS + 1;

  logic                         valid_r;
  logic signed [COORD_BITS-1:0] box_r [NUM_BOX];
  logic signed [COORD_BITS-1:0] vx_r [NUM_VERTS];
  logic signed [COORD_BITS-1:0] vy_r [NUM_VERTS];
  logic signed [NW-1:0]         nx_r [NUM_EDGES];
  logic signed [NW-1:0]         nx_nxt [NUM_EDGES];
  logic signed [NW-1:0]         ny_r [NUM_EDGES];
  logic signed [NW-1:0]         ny_nxt [NUM_EDGES];
  logic                         axis_sep_r;
  logic                         axis_sep_nxt;
  logic signed [COORD_BITS-1:0] tminx, tmaxx, tminy, tmaxy;
  logic signed [COORD_BITS-1:0] minx01, maxx01, miny01, maxy01;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      nx_nxt[e] = NW'(vy[EDGE_B[e]]) - NW'(vy[e]);
      ny_nxt[e] = NW'(vx[e]) - NW'(vx[EDGE_B[e]]);
    end
  end

  always_comb begin
    minx01 = (vx[1] < vx[0]) ? vx[1] : vx[0];
    maxx01 = (vx[1] > vx[0]) ? vx[1] : vx[0];
    miny01 = (vy[1] < vy[0]) ? vy[1] : vy[0];
    maxy01 = (vy[1] > vy[0]) ? vy[1] : vy[0];
    tminx  = (vx[2] < minx01) ? vx[2] : minx01;
    tmaxx  = (vx[2] > maxx01) ? vx[2] : maxx01;
    tminy  = (vy[2] < miny01) ? vy[2] : miny01;
    tmaxy  = (vy[2] > maxy01) ? vy[2] : maxy01;
    axis_sep_nxt = (tminx > box[BOX_MAX_X]) || (box[BOX_MIN_X] > tmaxx) ||
                   (tminy > box[BOX_MAX_Y]) || (box[BOX_MIN_Y] > tmaxy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      box_r      <= box;
      vx_r       <= vx;
      vy_r       <= vy;
      nx_r       <= nx_nxt;
      ny_r       <= ny_nxt;
      axis_sep_r <= axis_sep_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign box_out      = box_r;
  assign vx_out       = vx_r;
  assign vy_out       = vy_r;
  assign nx_out       = nx_r;
  assign ny_out       = ny_r;
  assign axis_sep_out = axis_sep_r;

endmodule

// File: hw/rtl/tbo_project.sv
// Middle stages: exact projections onto each edge normal, then interval bounds.
`include "triangle_box_overlap_2d_top_assert.svh"
module tbo_project #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_BITS-1:0]   box [tbo_pkg::NUM_BOX],
  input  logic signed [COORD_BITS-1:0]   vx [tbo_pkg::NUM_VERTS],
  input  logic signed [COORD_BITS-1:0]   vy [tbo_pkg::NUM_VERTS],
  input  logic signed [COORD_BITS:0]     nx [tbo_pkg::NUM_EDGES],
  input  logic signed [COORD_BITS:0]     ny [tbo_pkg::NUM_EDGES],
  input  logic                           axis_sep,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [2*COORD_BITS+1:0] bmin_out [tbo_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+1:0] bmax_out [tbo_pkg::NUM_EDGES],
  output logic signed [2*COORD_BITS+1:0] t_out [tbo_pkg::NUM_EDGES][tbo_pkg::NUM_VERTS],
  output logic                           axis_sep_out
);
  import tbo_pkg::*;

  localparam int PW = 2 * COORD_BITS + 1;
  localparam int SW = 2 * COORD_BITS + 2;

  // Product stage.
  logic                 vp_r;
  logic                 ready_p;
  logic signed [PW-1:0] pbx0_r [NUM_EDGES];
  logic signed [PW-1:0] pbx1_r [NUM_EDGES];
  logic signed [PW-1:0] pby0_r [NUM_EDGES];
  logic signed [PW-1:0] pby1_r [NUM_EDGES];
  logic signed [PW-1:0] ptx_r [NUM_EDGES][NUM_VERTS];
  logic signed [PW-1:0] pty_r [NUM_EDGES][NUM_VERTS];
  logic                 axis_p_r;

  // Sum stage.
  logic                 vc_r;
  logic signed [SW-1:0] bmin_r [NUM_EDGES];
  logic signed [SW-1:0] bmin_nxt [NUM_EDGES];
  logic signed [SW-1:0] bmax_r [NUM_EDGES];
  logic signed [SW-1:0] bmax_nxt [NUM_EDGES];
  logic signed [SW-1:0] t_r [NUM_EDGES][NUM_VERTS];
  logic signed [SW-1:0] t_nxt [NUM_EDGES][NUM_VERTS];
  logic                 axis_c_r;

  assign ready_p  = !vc_r || out_ready;
  assign in_ready = !vp_r || ready_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (in_ready) begin
        vp_r <= in_valid;
      end
      if (ready_p) begin
        vc_r <= vp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      for (int e = 0; e < NUM_EDGES; e++) begin
        pbx0_r[e] <= PW'(nx[e]) * PW'(box[BOX_MIN_X]);
        pbx1_r[e] <= PW'(nx[e]) * PW'(box[BOX_MAX_X]);
        pby0_r[e] <= PW'(ny[e]) * PW'(box[BOX_MIN_Y]);
        pby1_r[e] <= PW'(ny[e]) * PW'(box[BOX_MAX_Y]);
        for (int i = 0; i < NUM_VERTS; i++) begin
          ptx_r[e][i] <= PW'(nx[e]) * PW'(vx[i]);
          pty_r[e][i] <= PW'(ny[e]) * PW'(vy[i]);
        end
      end
      axis_p_r <= axis_sep;
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      bmin_nxt[e] = SW'((pbx0_r[e] < pbx1_r[e]) ? pbx0_r[e] : pbx1_r[e]) +
                    SW'((pby0_r[e] < pby1_r[e]) ? pby0_r[e] : pby1_r[e]);
      bmax_nxt[e] = SW'((pbx0_r[e] > pbx1_r[e]) ? pbx0_r[e] : pbx1_r[e]) +
                    SW'((pby0_r[e] > pby1_r[e]) ? pby0_r[e] : pby1_r[e]);
      for (int i = 0; i < NUM_VERTS; i++) begin
        t_nxt[e][i] = SW'(ptx_r[e][i]) + SW'(pty_r[e][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_p && vp_r) begin
      bmin_r   <= bmin_nxt;
      bmax_r   <= bmax_nxt;
      t_r      <= t_nxt;
      axis_c_r <= axis_p_r;
    end
  end

  assign out_valid    = vc_r;
  assign bmin_out     = bmin_r;
  assign bmax_out     = bmax_r;
  assign t_out        = t_r;
  assign axis_sep_out = axis_c_r;

  `TBO_ASSERT_NEXT(a_sum_held, clk, rst_n, vc_r && !out_ready, vc_r,
    "Sum stage dropped an item while stalled")
  `TBO_ASSERT_NEXT(a_prod_held, clk, rst_n, vp_r && !ready_p, vp_r,
    "Product stage dropped an item while stalled")

endmodule

// File: hw/rtl/tbo_decide.sv
// Last stage: triangle interval per edge, separation tests and the result register.
`include "triangle_box_overlap_2d_top_assert.svh"
module tbo_decide #(
  parameter int COORD_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [2*COORD_BITS+1:0] bmin [tbo_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+1:0] bmax [tbo_pkg::NUM_EDGES],
  input  logic signed [2*COORD_BITS+1:0] t [tbo_pkg::NUM_EDGES][tbo_pkg::NUM_VERTS],
  input  logic                           axis_sep,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           overlaps,
  output tbo_pkg::reason_t               reason
);
  import tbo_pkg::*;

  localparam int SW = 2 * COORD_BITS + 2;

  logic                 valid_r;
  logic                 overlaps_r;
  logic                 overlaps_nxt;
  reason_t              reason_r;
  reason_t              reason_nxt;
  logic signed [SW-1:0] tmin01 [NUM_EDGES];
  logic signed [SW-1:0] tmax01 [NUM_EDGES];
  logic signed [SW-1:0] tmin [NUM_EDGES];
  logic signed [SW-1:0] tmax [NUM_EDGES];
  logic [NUM_EDGES-1:0] edge_sep;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      tmin01[e]   = (t[e][1] < t[e][0]) ? t[e][1] : t[e][0];
      tmax01[e]   = (t[e][1] > t[e][0]) ? t[e][1] : t[e][0];
      tmin[e]     = (t[e][2] < tmin01[e]) ? t[e][2] : tmin01[e];
      tmax[e]     = (t[e][2] > tmax01[e]) ? t[e][2] : tmax01[e];
      edge_sep[e] = (tmax[e] < bmin[e]) || (bmax[e] < tmin[e]);
    end
  end

  always_comb begin
    if (axis_sep) begin
      reason_nxt = REASON_AXIS;
    end else if (|edge_sep) begin
      reason_nxt = REASON_EDGE;
    end else begin
      reason_nxt = REASON_OVERLAP;
    end
    overlaps_nxt = (reason_nxt == REASON_OVERLAP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      reason_r   <= reason_nxt;
      overlaps_r <= overlaps_nxt;
    end
  end

  assign out_valid = valid_r;
  assign overlaps  = overlaps_r;
  assign reason    = reason_r;

  `TBO_ASSERT_NEXT(a_axis_wins, clk, rst_n, in_valid && in_ready && axis_sep,
    reason_r == REASON_AXIS, "Axis separation did not give the axis reason")
  `TBO_ASSERT_NOW(a_flag_match, clk, rst_n, valid_r,
    overlaps_r == (reason_r == REASON_OVERLAP), "Overlap flag disagrees with reason")

endmodule

// File: hw/rtl/triangle_box_overlap_2d_top.sv
// Top level of the 2D triangle versus axis-aligned box overlap test.
// Usage:
//   in_ch carries one box (min and max corners) and one triangle (three
//   vertices), all signed Q12.4 of COORD_BITS bits; a transfer happens
//   at a rising edge with valid and ready both high.
//   out_ch carries one result per input: overlaps and reject_reason
//   (0 overlap, 1 separated on x or y, 2 separated on an edge normal).
// Timing:
//   Four register stages: setup with normals and the axis test, exact
//   products, interval sums, then the decision and output register.
//   An input passes through these stages in order, and one item per cycle
//   is sustained while out_ch.ready stays high.
// Stalls:
//   Each stage holds its item while the next one is full and cannot take it, so bubbles
//   collapse and input is still taken while a result waits; with all
//   four stages full and out_ch.ready low, in_ch.ready drops.
// Reset:
//   The synchronous active-low reset empties all stages; no other state.
module triangle_box_overlap_2d_top #(
  parameter int COORD_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tbo_in_if.sink    in_ch,
  tbo_out_if.source out_ch
);
  import tbo_pkg::*;

  localparam int SW = 2 * COORD_BITS + 2;

  logic signed [COORD_BITS-1:0] box [NUM_BOX];
  logic signed [COORD_BITS-1:0] vx [NUM_VERTS];
  logic signed [COORD_BITS-1:0] vy [NUM_VERTS];

  logic                         s_valid, s_ready;
  logic signed [COORD_BITS-1:0] s_box [NUM_BOX];
  logic signed [COORD_BITS-1:0] s_vx [NUM_VERTS];
  logic signed [COORD_BITS-1:0] s_vy [NUM_VERTS];
  logic signed [COORD_BITS:0]   s_nx [NUM_EDGES];
  logic signed [COORD_BITS:0]   s_ny [NUM_EDGES];
  logic                         s_axis;

  logic                 p_valid, p_ready;
  logic signed [SW-1:0] p_bmin [NUM_EDGES];
  logic signed [SW-1:0] p_bmax [NUM_EDGES];
  logic signed [SW-1:0] p_t [NUM_EDGES][NUM_VERTS];
  logic                 p_axis;

  reason_t reason;

  assign box[BOX_MIN_X] = in_ch.box_min_x;
  assign box[BOX_MIN_Y] = in_ch.box_min_y;
  assign box[BOX_MAX_X] = in_ch.box_max_x;
  assign box[BOX_MAX_Y] = in_ch.box_max_y;
  assign vx[0] = in_ch.vertex0_x;
  assign vy[0] = in_ch.vertex0_y;
  assign vx[1] = in_ch.vertex1_x;
  assign vy[1] = in_ch.vertex1_y;
  assign vx[2] = in_ch.vertex2_x;
  assign vy[2] = in_ch.vertex2_y;

  tbo_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .box          (box),
    .vx           (vx),
    .vy           (vy),
    .out_valid    (s_valid),
    .out_ready    (s_ready),
    .box_out      (s_box),
    .vx_out       (s_vx),
    .vy_out       (s_vy),
    .nx_out       (s_nx),
    .ny_out       (s_ny),
    .axis_sep_out (s_axis)
  );

  tbo_project #(.COORD_BITS(COORD_BITS)) u_project (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s_valid),
    .in_ready     (s_ready),
    .box          (s_box),
    .vx           (s_vx),
    .vy           (s_vy),
    .nx           (s_nx),
    .ny           (s_ny),
    .axis_sep     (s_axis),
    .out_valid    (p_valid),
    .out_ready    (p_ready),
    .bmin_out     (p_bmin),
    .bmax_out     (p_bmax),
    .t_out        (p_t),
    .axis_sep_out (p_axis)
  );

  tbo_decide #(.COORD_BITS(COORD_BITS)) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .bmin      (p_bmin),
    .bmax      (p_bmax),
    .t         (p_t),
    .axis_sep  (p_axis),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .overlaps  (out_ch.overlaps),
    .reason    (reason)
  );

  assign out_ch.reject_reason = reason;

endmodule
